[design/open_node_table_manager_macros.svh]
// Assertion macros shared by the open node table manager RTL.
`ifndef OPEN_NODE_TABLE_MANAGER_MACROS_SVH
`define OPEN_NODE_TABLE_MANAGER_MACROS_SVH
`ifndef SYNTH
`define ONT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");
`define ONT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");
`else
`define ONT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ONT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/ont_pkg.sv]
// Types and codes of the open node table manager.
`timescale 1ns / 1ps

package ont_pkg;

    localparam logic [2:0] CMD_OPEN         = 3'd0;
    localparam logic [2:0] CMD_CLOSE        = 3'd1;
    localparam logic [2:0] CMD_FLUSH        = 3'd2;
    localparam logic [2:0] CMD_INV_ADDR     = 3'd3;
    localparam logic [2:0] CMD_INV_DEV_ADDR = 3'd4;
    localparam logic [2:0] CMD_MARK_DIRTY   = 3'd5;

    localparam logic [2:0] KIND_OPENED       = 3'd0;
    localparam logic [2:0] KIND_WRITE_BACK   = 3'd1;
    localparam logic [2:0] KIND_FETCH        = 3'd2;
    localparam logic [2:0] KIND_ALREADY_OPEN = 3'd3;
    localparam logic [2:0] KIND_TABLE_FULL   = 3'd4;
    localparam logic [2:0] KIND_DONE         = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  device;
        logic [31:0] block_address;
        logic [3:0]  slot;
        logic [15:0] owner;
    } request_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  result_slot;
        logic [7:0]  result_device;
        logic [31:0] result_address;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] owner;
        logic [7:0]  device;
        logic [31:0] address;
    } entry_t;

endpackage

[design/open_node_table_manager.sv]
// Top level of the open node table manager: entry memory, flags and command sequencer.
`timescale 1ns / 1ps
`include "open_node_table_manager_macros.svh"

// A request is taken when start is high and busy is low. Close, mark dirty and
// unknown commands finish in the accept cycle: busy stays low and their done result
// is strobed in the next cycle. Open, flush and both invalidates walk the entry
// memory one entry per cycle, since the keys sit in a memory with one read port and
// one read per cycle, and busy stays high while they run. An open stops at the entry
// whose key matches; else it walks the whole table and reports the table full, or
// claims a clean idle entry (fetch, then opened), or writes a dirty idle entry back
// first (write back, fetch, opened). Flush and invalidate walk the whole table, then
// report done. The final result of every request is strobed in the first cycle
// with busy low again. Results are strobed for one cycle each and cannot be held
// off, so the receiver must take every strobed result.
module open_node_table_manager #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ont_pkg::request_t request,
    output ont_pkg::result_t  result,
    output logic              result_strobe
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_WB     = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_OPENED = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    function automatic ont_pkg::result_t make_result(
        input logic [2:0]  kind,
        input logic [3:0]  slot,
        input logic [7:0]  device,
        input logic [31:0] address,
        input logic        last
    );
        ont_pkg::result_t r;
        r.kind           = kind;
        r.result_slot    = slot;
        r.result_device  = device;
        r.result_address = address;
        r.last           = last;
        return r;
    endfunction

    state_t                   state_reg, state_next;
    ont_pkg::request_t        req_reg, req_next;
    logic [IW-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]            pick_reg, pick_next;
    logic                     clean_found_reg, clean_found_next;
    logic                     dirty_found_reg, dirty_found_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0] busy_reg, busy_next;
    logic [TABLE_ENTRIES-1:0] dirty_reg, dirty_next;
    ont_pkg::result_t         res_reg, res_next;
    logic                     strobe_reg, strobe_next;

    ont_pkg::entry_t          mem [TABLE_ENTRIES];
    ont_pkg::entry_t          rd_data_reg;
    logic [IW-1:0]            rd_addr;
    logic                     mem_we;
    logic [IW-1:0]            mem_waddr;
    ont_pkg::entry_t          mem_wdata;

    logic                     cmp_last;
    logic                     key_match;
    logic                     addr_match;
    logic                     idle_clean;
    logic                     idle_dirty;
    logic                     slot_ok;
    logic [IW-1:0]            slot_idx;

    assign cmp_last   = (cmp_idx_reg == IW'(TABLE_ENTRIES - 1));
    assign addr_match = valid_reg[cmp_idx_reg]
                        && (rd_data_reg.address == req_reg.block_address);
    assign key_match  = addr_match && (rd_data_reg.device == req_reg.device);
    assign idle_clean = !busy_reg[cmp_idx_reg] && !dirty_reg[cmp_idx_reg];
    assign idle_dirty = !busy_reg[cmp_idx_reg] && dirty_reg[cmp_idx_reg];
    assign slot_ok    = (32'(request.slot) < TABLE_ENTRIES);
    assign slot_idx   = IW'(request.slot);

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        cmp_idx_next     = cmp_idx_reg;
        pick_next        = pick_reg;
        clean_found_next = clean_found_reg;
        dirty_found_next = dirty_found_reg;
        valid_next       = valid_reg;
        busy_next        = busy_reg;
        dirty_next       = dirty_reg;
        res_next         = '0;
        strobe_next      = 1'b0;
        rd_addr          = '0;
        mem_we           = 1'b0;
        mem_waddr        = pick_reg;
        mem_wdata.owner   = req_reg.owner;
        mem_wdata.device  = req_reg.device;
        mem_wdata.address = req_reg.block_address;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    case (request.command)
                        ont_pkg::CMD_OPEN, ont_pkg::CMD_FLUSH,
                        ont_pkg::CMD_INV_ADDR, ont_pkg::CMD_INV_DEV_ADDR:
                        begin
                            state_next       = ST_SCAN;
                            cmp_idx_next     = '0;
                            clean_found_next = 1'b0;
                            dirty_found_next = 1'b0;
                        end
                        ont_pkg::CMD_CLOSE:
                        begin
                            if (slot_ok)
                            begin
                                busy_next[slot_idx] = 1'b0;
                            end
                            res_next    = make_result(ont_pkg::KIND_DONE, request.slot,
                                                      8'd0, 32'd0, 1'b1);
                            strobe_next = 1'b1;
                        end
                        ont_pkg::CMD_MARK_DIRTY:
                        begin
                            if (slot_ok && valid_reg[slot_idx])
                            begin
                                dirty_next[slot_idx] = 1'b1;
                            end
                            res_next    = make_result(ont_pkg::KIND_DONE, request.slot,
                                                      8'd0, 32'd0, 1'b1);
                            strobe_next = 1'b1;
                        end
                        default:
                        begin
                            res_next    = make_result(ont_pkg::KIND_DONE, 4'd0,
                                                      8'd0, 32'd0, 1'b1);
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmp_idx_next = IW'(cmp_idx_reg + 1'b1);
                case (req_reg.command)
                    ont_pkg::CMD_OPEN:
                    begin
                        if (key_match)
                        begin
                            if (busy_reg[cmp_idx_reg])
                            begin
                                res_next = make_result(ont_pkg::KIND_ALREADY_OPEN,
                                                       4'(cmp_idx_reg), 8'd0, 32'd0, 1'b1);
                            end
                            else
                            begin
                                busy_next[cmp_idx_reg] = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = cmp_idx_reg;
                                res_next  = make_result(ont_pkg::KIND_OPENED,
                                                        4'(cmp_idx_reg), 8'd0, 32'd0, 1'b1);
                            end
                            strobe_next = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            if (!clean_found_reg)
                            begin
                                if (idle_clean)
                                begin
                                    clean_found_next = 1'b1;
                                    pick_next        = cmp_idx_reg;
                                end
                                else if (idle_dirty)
                                begin
                                    dirty_found_next = 1'b1;
                                    pick_next        = cmp_idx_reg;
                                end
                            end
                            if (cmp_last)
                            begin
                                if (clean_found_next)
                                begin
                                    state_next = ST_FETCH;
                                end
                                else if (dirty_found_next)
                                begin
                                    state_next = ST_WB;
                                end
                                else
                                begin
                                    res_next    = make_result(ont_pkg::KIND_TABLE_FULL, 4'd0,
                                                              8'd0, 32'd0, 1'b1);
                                    strobe_next = 1'b1;
                                    state_next  = ST_IDLE;
                                end
                            end
                        end
                        rd_addr = cmp_last ? pick_next : IW'(cmp_idx_reg + 1'b1);
                    end
                    ont_pkg::CMD_FLUSH:
                    begin
                        if (valid_reg[cmp_idx_reg] && dirty_reg[cmp_idx_reg]
                            && (rd_data_reg.device == req_reg.device))
                        begin
                            dirty_next[cmp_idx_reg] = 1'b0;
                            res_next    = make_result(ont_pkg::KIND_WRITE_BACK,
                                                      4'(cmp_idx_reg), req_reg.device,
                                                      rd_data_reg.address, 1'b0);
                            strobe_next = 1'b1;
                        end
                        rd_addr = IW'(cmp_idx_reg + 1'b1);
                        if (cmp_last)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    ont_pkg::CMD_INV_ADDR, ont_pkg::CMD_INV_DEV_ADDR:
                    begin
                        if ((req_reg.command == ont_pkg::CMD_INV_ADDR) ? addr_match : key_match)
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            busy_next[cmp_idx_reg]  = 1'b0;
                            dirty_next[cmp_idx_reg] = 1'b0;
                        end
                        rd_addr = IW'(cmp_idx_reg + 1'b1);
                        if (cmp_last)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WB:
            begin
                res_next    = make_result(ont_pkg::KIND_WRITE_BACK, 4'(pick_reg),
                                          rd_data_reg.device, rd_data_reg.address, 1'b0);
                strobe_next = 1'b1;
                state_next  = ST_FETCH;
            end
            ST_FETCH:
            begin
                mem_we               = 1'b1;
                valid_next[pick_reg] = 1'b1;
                busy_next[pick_reg]  = 1'b1;
                dirty_next[pick_reg] = 1'b0;
                res_next    = make_result(ont_pkg::KIND_FETCH, 4'(pick_reg),
                                          req_reg.device, req_reg.block_address, 1'b0);
                strobe_next = 1'b1;
                state_next  = ST_OPENED;
            end
            ST_OPENED:
            begin
                res_next    = make_result(ont_pkg::KIND_OPENED, 4'(pick_reg),
                                          8'd0, 32'd0, 1'b1);
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DONE:
            begin
                res_next    = make_result(ont_pkg::KIND_DONE, 4'd0, 8'd0, 32'd0, 1'b1);
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmp_idx_reg     <= '0;
            pick_reg        <= '0;
            clean_found_reg <= 1'b0;
            dirty_found_reg <= 1'b0;
            valid_reg       <= '0;
            busy_reg        <= '0;
            dirty_reg       <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmp_idx_reg     <= cmp_idx_next;
            pick_reg        <= pick_next;
            clean_found_reg <= clean_found_next;
            dirty_found_reg <= dirty_found_next;
            valid_reg       <= valid_next;
            busy_reg        <= busy_next;
            dirty_reg       <= dirty_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result        = res_reg;
    assign result_strobe = strobe_reg;

    `ONT_ASSERT_IMP(busy_implies_valid, clk, rst_n, 1'b1, (busy_reg & ~valid_reg) == '0)
    `ONT_ASSERT_IMP(dirty_implies_valid, clk, rst_n, 1'b1, (dirty_reg & ~valid_reg) == '0)
    `ONT_ASSERT_IMP(last_result_frees_block, clk, rst_n, result_strobe && result.last, !busy)
    `ONT_ASSERT_NEXT(fetch_then_opened, clk, rst_n,
        result_strobe && (result.kind == ont_pkg::KIND_FETCH),
        result_strobe && (result.kind == ont_pkg::KIND_OPENED) && result.last)
    `ONT_ASSERT_NEXT(close_answers_next, clk, rst_n,
        start && !busy && (request.command == ont_pkg::CMD_CLOSE),
        result_strobe && result.last && (result.kind == ont_pkg::KIND_DONE))

endmodule

[bench/open_node_table_manager_tb.sv]
// Self-checking testbench of the open node table manager with a table predictor.
`timescale 1ns / 1ps

module open_node_table_manager_tb;

    localparam int NODES = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        ont_pkg::request_t cmd;
        int unsigned       copies;
        bit                typed;
        ont_pkg::result_t  answer;
    } script_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    ont_pkg::request_t request;
    ont_pkg::result_t  result;
    logic              result_strobe;

    bit          node_valid [NODES];
    bit          node_open [NODES];
    bit          node_dirty [NODES];
    logic [7:0]  node_device [NODES];
    logic [31:0] node_address [NODES];
    logic [15:0] node_owner [NODES];

    ont_pkg::result_t replies_due[$];
    script_row_t      script[$];
    logic [7:0]       device_pool [4];
    logic [31:0]      address_pool [24];
    int unsigned      idle_pct;
    int unsigned      mismatches;
    int unsigned      quiet_cycles;
    ont_pkg::result_t oldest;

    open_node_table_manager #(
        .TABLE_ENTRIES(NODES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_strobe(result_strobe)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic ont_pkg::result_t reply(input logic [2:0] kind, input logic [3:0] slot,
                                               input logic [7:0] dev, input logic [31:0] addr,
                                               input logic last);
        ont_pkg::result_t r;
        r.kind = kind;
        r.result_slot = slot;
        r.result_device = dev;
        r.result_address = addr;
        r.last = last;
        return r;
    endfunction

    function automatic string show(input ont_pkg::result_t r);
        return $sformatf("kind %0d slot %0d device %h address %h last %b",
                         r.kind, r.result_slot, r.result_device, r.result_address, r.last);
    endfunction

    // Applies one request to the table copy and lists the results it must produce.
    function automatic void run_table_command(input ont_pkg::request_t r,
                                              ref ont_pkg::result_t replies[$]);
        int hit;
        int clean;
        int dirty;
        hit = -1;
        clean = -1;
        dirty = -1;
        replies = {};
        case (r.command)
            ont_pkg::CMD_OPEN:
            begin
                for (int i = 0; i < NODES; i++)
                    if (hit < 0 && node_valid[i] && node_device[i] == r.device
                        && node_address[i] == r.block_address)
                        hit = i;
                if (hit >= 0)
                begin
                    if (node_open[hit])
                        replies.push_back(reply(ont_pkg::KIND_ALREADY_OPEN, 4'(hit),
                                                8'h00, 32'h0, 1'b1));
                    else
                    begin
                        node_open[hit] = 1'b1;
                        node_owner[hit] = r.owner;
                        replies.push_back(reply(ont_pkg::KIND_OPENED, 4'(hit),
                                                8'h00, 32'h0, 1'b1));
                    end
                end
                else
                begin
                    for (int i = 0; i < NODES; i++)
                        if (clean < 0 && !node_open[i])
                        begin
                            if (!node_dirty[i])
                                clean = i;
                            else
                                dirty = i;
                        end
                    if (clean < 0 && dirty < 0)
                        replies.push_back(reply(ont_pkg::KIND_TABLE_FULL, 4'd0,
                                                8'h00, 32'h0, 1'b1));
                    else
                    begin
                        if (clean < 0)
                        begin
                            clean = dirty;
                            replies.push_back(reply(ont_pkg::KIND_WRITE_BACK, 4'(clean),
                                                    node_device[clean], node_address[clean],
                                                    1'b0));
                        end
                        replies.push_back(reply(ont_pkg::KIND_FETCH, 4'(clean), r.device,
                                                r.block_address, 1'b0));
                        node_valid[clean] = 1'b1;
                        node_open[clean] = 1'b1;
                        node_dirty[clean] = 1'b0;
                        node_device[clean] = r.device;
                        node_address[clean] = r.block_address;
                        node_owner[clean] = r.owner;
                        replies.push_back(reply(ont_pkg::KIND_OPENED, 4'(clean),
                                                8'h00, 32'h0, 1'b1));
                    end
                end
            end
            ont_pkg::CMD_CLOSE:
            begin
                node_open[r.slot] = 1'b0;
                replies.push_back(reply(ont_pkg::KIND_DONE, r.slot, 8'h00, 32'h0, 1'b1));
            end
            ont_pkg::CMD_FLUSH:
            begin
                for (int i = 0; i < NODES; i++)
                    if (node_valid[i] && node_dirty[i] && node_device[i] == r.device)
                    begin
                        replies.push_back(reply(ont_pkg::KIND_WRITE_BACK, 4'(i), r.device,
                                                node_address[i], 1'b0));
                        node_dirty[i] = 1'b0;
                    end
                replies.push_back(reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
            end
            ont_pkg::CMD_INV_ADDR, ont_pkg::CMD_INV_DEV_ADDR:
            begin
                for (int i = 0; i < NODES; i++)
                    if (node_valid[i] && node_address[i] == r.block_address
                        && (r.command == ont_pkg::CMD_INV_ADDR
                            || node_device[i] == r.device))
                    begin
                        node_valid[i] = 1'b0;
                        node_open[i] = 1'b0;
                        node_dirty[i] = 1'b0;
                    end
                replies.push_back(reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
            end
            ont_pkg::CMD_MARK_DIRTY:
            begin
                if (node_valid[r.slot])
                    node_dirty[r.slot] = 1'b1;
                replies.push_back(reply(ont_pkg::KIND_DONE, r.slot, 8'h00, 32'h0, 1'b1));
            end
            default:
                replies.push_back(reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
        endcase
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [7:0] dev, input logic [31:0] addr,
                           input logic [3:0] slot, input logic [15:0] owner,
                           input int unsigned copies, input bit typed,
                           input ont_pkg::result_t answer);
        script_row_t row;
        row.cmd.command = cmd;
        row.cmd.device = dev;
        row.cmd.block_address = addr;
        row.cmd.slot = slot;
        row.cmd.owner = owner;
        row.copies = copies;
        row.typed = typed;
        row.answer = answer;
        script.push_back(row);
    endtask

    function automatic logic [7:0] pick_device();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return device_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [31:0] pick_address();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return address_pool[$urandom_range(0, 23)];
    endfunction

    // Mostly names a slot that is open or valid, so that closes and marks take effect.
    function automatic logic [3:0] pick_slot(input bit want_open);
        int base;
        int found;
        base = int'($urandom_range(0, NODES - 1));
        found = -1;
        for (int k = 0; k < NODES; k++)
            if (found < 0 && (want_open ? node_open[(base + k) % NODES]
                                        : node_valid[(base + k) % NODES]))
                found = (base + k) % NODES;
        if (found < 0 || $urandom_range(0, 4) == 0)
            return 4'(base);
        return 4'(found);
    endfunction

    function automatic ont_pkg::request_t random_request();
        ont_pkg::request_t r;
        int unsigned pick;
        r.command = 3'($urandom_range(0, 5));
        r.device = 8'($urandom);
        r.block_address = $urandom;
        r.slot = 4'($urandom);
        r.owner = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.command = ont_pkg::CMD_OPEN;
            r.device = pick_device();
            r.block_address = pick_address();
        end
        else if (pick < 65)
        begin
            r.command = ont_pkg::CMD_CLOSE;
            r.slot = pick_slot(1'b1);
        end
        else if (pick < 80)
        begin
            r.command = ont_pkg::CMD_MARK_DIRTY;
            r.slot = pick_slot(1'b0);
        end
        else if (pick < 88)
        begin
            r.command = ont_pkg::CMD_FLUSH;
            r.device = pick_device();
        end
        else if (pick < 93)
        begin
            r.command = ont_pkg::CMD_INV_ADDR;
            r.block_address = pick_address();
        end
        else if (pick < 97)
        begin
            r.command = ont_pkg::CMD_INV_DEV_ADDR;
            r.device = pick_device();
            r.block_address = pick_address();
        end
        return r;
    endfunction

    task automatic send_request(input ont_pkg::request_t r, input bit typed,
                                input ont_pkg::result_t answer);
        ont_pkg::result_t replies[$];
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        run_table_command(r, replies);
        if (typed)
            replies = {answer};
        foreach (replies[i])
            replies_due.push_back(replies[i]);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (replies_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected: expected nothing, actual %s",
                         $time, show(result));
            end
            else
            begin
                oldest = replies_due.pop_front();
                if (result !== oldest)
                begin
                    mismatches++;
                    $display("%0t: mismatch: expected %s, actual %s",
                             $time, show(oldest), show(result));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        ont_pkg::request_t r;
        int unsigned       phase_idle [4];
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        idle_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        phase_idle = '{0, 83, 0, 20};
        foreach (device_pool[i])
            device_pool[i] = 8'($urandom);
        foreach (address_pool[i])
            address_pool[i] = $urandom;

        // The empty table answers plain done; then the extremes of the keys are opened,
        // reused, flushed, the table is filled, and a dirty idle entry is reclaimed.
        add_row(ont_pkg::CMD_CLOSE, 8'h00, 32'h0000_0000, 4'd0, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_MARK_DIRTY, 8'hFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd15, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_FLUSH, 8'h00, 32'h0000_0000, 4'd0, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(CMD_SPARE_6, 8'hFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(CMD_SPARE_7, 8'h5A, 32'h1234_5678, 4'd9, 16'h0F0F, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_OPEN, 8'h00, 32'h0000_0000, 4'd0, 16'h0000, 1, 1'b0, '0);
        add_row(ont_pkg::CMD_OPEN, 8'h00, 32'h0000_0000, 4'd7, 16'h0001, 1, 1'b1,
                reply(ont_pkg::KIND_ALREADY_OPEN, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_OPEN, 8'hFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF, 1, 1'b0, '0);
        add_row(ont_pkg::CMD_MARK_DIRTY, 8'h00, 32'h0000_0000, 4'd1, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd1, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_FLUSH, 8'hFF, 32'h0000_0000, 4'd0, 16'h0000, 1, 1'b0, '0);
        add_row(ont_pkg::CMD_MARK_DIRTY, 8'h00, 32'h0000_0000, 4'd1, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd1, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_CLOSE, 8'h00, 32'h0000_0000, 4'd1, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd1, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_OPEN, 8'hFF, 32'hFFFF_FFFF, 4'd0, 16'h1234, 1, 1'b1,
                reply(ont_pkg::KIND_OPENED, 4'd1, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_OPEN, 8'h12, 32'h0000_0100, 4'd0, 16'h0100, NODES - 2, 1'b0, '0);
        add_row(ont_pkg::CMD_OPEN, 8'h12, 32'h0000_0200, 4'd0, 16'h0200, 1, 1'b1,
                reply(ont_pkg::KIND_TABLE_FULL, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_MARK_DIRTY, 8'h00, 32'h0000_0000, 4'd5, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd5, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_MARK_DIRTY, 8'h00, 32'h0000_0000, 4'd7, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd7, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_CLOSE, 8'h00, 32'h0000_0000, 4'd5, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd5, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_CLOSE, 8'h00, 32'h0000_0000, 4'd7, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd7, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_OPEN, 8'h03, 32'h0000_0055, 4'd0, 16'h0003, 1, 1'b0, '0);
        add_row(ont_pkg::CMD_INV_ADDR, 8'hA5, 32'h0000_0102, 4'd3, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_INV_DEV_ADDR, 8'h12, 32'h0000_0103, 4'd0, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_INV_DEV_ADDR, 8'h13, 32'h0000_0104, 4'd0, 16'h0000, 1, 1'b1,
                reply(ont_pkg::KIND_DONE, 4'd0, 8'h00, 32'h0, 1'b1));
        add_row(ont_pkg::CMD_OPEN, 8'h12, 32'h0000_0300, 4'd0, 16'h0300, 1, 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            for (int unsigned k = 0; k < script[i].copies; k++)
            begin
                r = script[i].cmd;
                r.block_address = r.block_address + k;
                r.owner = r.owner + 16'(k);
                send_request(r, script[i].typed, script[i].answer);
            end

        foreach (phase_idle[p])
        begin
            idle_pct = phase_idle[p];
            repeat (100) send_request(random_request(), 1'b0, '0);
        end
        start <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/ont_pkg.sv
design/open_node_table_manager.sv
bench/open_node_table_manager_tb.sv
